### rtl/cfog_pkg.sv
// cfog_pkg: shared types, widths and constants of the crossfade output gate.
// Holds the sequencer state type and the quarter-sine generator used by the ROM.
// No dependencies.
package cfog_pkg;

  localparam int SMP_W      = 16;   // audio sample width
  localparam int CNT_W      = 20;   // fade counter / fade length width
  localparam int GAIN_W     = 16;   // Q1.15 gain, always below 32768
  localparam int DIVIDEND_W = 36;   // covers c*entries and d*r + len/2
  localparam int SEL_W      = 5;    // select field width
  localparam int CH_W       = 3;    // channel field width
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 3;
  localparam int MUL_AW     = CNT_W + 1;   // unsigned 20-bit operand, signed form
  localparam int MUL_BW     = SMP_W + 1;   // sample, table delta or entry count
  localparam int PROD_W     = MUL_AW + MUL_BW;

  // register indexes
  localparam logic REG_FADE_LENGTH = 1'b0;

  localparam logic [CNT_W-1:0] FADE_LENGTH_RST = CNT_W'(1);

  // pi/2 in Q30 and the Taylor denominators (2n)(2n+1)
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                             64'd110, 64'd156, 64'd210, 64'd272};

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,      // counter read in flight
    S_UPD,     // counter step and write-back
    S_MUL1,    // c * entries
    S_DIV1,    // start table index divide
    S_DIV1_W,
    S_ROM0,    // fetch T[i]
    S_ROM1,    // fetch T[i+1]
    S_ROM2,
    S_MUL2,    // delta * r
    S_DIV2,    // start interpolation divide
    S_DIV2_W,
    S_MUL3,    // sample * gain
    S_OUT
  } st_t;

  // sin(x) in Q15 from x in Q30, Taylor series of x plus eight further terms; elaboration only
  function automatic logic [15:0] sine_q15(input logic [63:0] x);
    logic [63:0] t;
    longint      sum;
    logic [63:0] q;
    t   = x;
    sum = longint'(x);
    for (int n = 1; n <= 8; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / TAYLOR_DIV[n-1];
      if ((n & 1) != 0) sum = sum - longint'(t);
      else sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    q = ((64'(sum) * 64'd32768) + (64'd1 << 29)) >> 30;
    if (q > 64'd32767) q = 64'd32767;
    return q[15:0];
  endfunction

endpackage

### rtl/crossfade_output_gate_unit.sv
// crossfade_output_gate_unit: routes one audio input to OUTPUTS outputs with
// equal-power fades. A select request is taken while idle. A sample request
// sweeps all outputs; per output two passes of the shared restoring divider
// dominate (one at full gain, no interpolation), and a stalled result register holds it.
// Reset (rst_n low, sync): no output active, counters read zero, length = 1.
// Depends on cfog_pkg, cfog_ram, cfog_sine_rom, cfog_divider.
module crossfade_output_gate_unit
  import cfog_pkg::*;
#(
  parameter int OUTPUTS      = 8,
  parameter int SINE_ENTRIES = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // sample / select requests
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_action,
  input  logic signed [SMP_W-1:0]  in_sample_in,
  input  logic signed [SEL_W-1:0]  in_select_out,
  // per-output results
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [CH_W-1:0]          out_channel,
  output logic signed [SMP_W-1:0]  out_sample_out,
  output logic                     out_faded_out,
  output logic                     out_last,
  // configuration
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_AW-1:0]        cfg_paddr,
  input  logic [CFG_DW-1:0]        cfg_pwdata,
  output logic [CFG_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  localparam int IDX_W  = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int CUR_W  = $clog2(OUTPUTS + 1);
  localparam int TAB_AW = $clog2(SINE_ENTRIES + 1);

  // ---------------------------------------------------------------------
  // Configuration: one register, fade_length, at byte address 0.
  // ---------------------------------------------------------------------
  logic [CNT_W-1:0] fade_len_r, fade_len_nxt;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_FADE_LENGTH) ? CFG_DW'(fade_len_r) : '0;

  always_comb begin
    fade_len_nxt = fade_len_r;
    if (cfg_wr && cfg_paddr[2] == REG_FADE_LENGTH) fade_len_nxt = cfg_pwdata[CNT_W-1:0];
  end

  // ---------------------------------------------------------------------
  // Sequencer and datapath registers
  // ---------------------------------------------------------------------
  st_t                      state_r, state_nxt;
  logic [OUTPUTS-1:0]       act_r, act_nxt;        // active flags, one per output
  logic [OUTPUTS-1:0]       cnt_vld_r, cnt_vld_nxt; // counter written since reset
  logic [CUR_W-1:0]         cur_r, cur_nxt;        // selected output, 0 = none
  logic [IDX_W-1:0]         k_r, k_nxt;
  logic [CNT_W-1:0]         len_r, len_nxt;        // effective length, latched
  logic signed [SMP_W-1:0]  smp_r, smp_nxt;
  logic [CNT_W-1:0]         c_r, c_nxt;            // counter clamped to length
  logic                     faded_r, faded_nxt;
  logic [TAB_AW-1:0]        i_r, i_nxt;
  logic [CNT_W-1:0]         r_r, r_nxt;
  logic [GAIN_W-1:0]        t0_r, t0_nxt;
  logic [GAIN_W-1:0]        t1_r, t1_nxt;
  logic [GAIN_W-1:0]        gain_r, gain_nxt;
  logic signed [PROD_W-1:0] prod_r;

  // result register
  logic                     out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]          out_ch_r, out_ch_nxt;
  logic signed [SMP_W-1:0]  out_smp_r, out_smp_nxt;
  logic                     out_fd_r, out_fd_nxt;
  logic                     out_last_r, out_last_nxt;

  // shared multiplier operands
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;

  // divider hookup
  logic                     div_start;
  logic [DIVIDEND_W-1:0]    div_dividend;
  logic                     div_done;
  logic [DIVIDEND_W-1:0]    div_quot;
  logic [CNT_W-1:0]         div_rem;

  // counter RAM and sine ROM
  logic                     cnt_we;
  logic [CNT_W-1:0]         cnt_wdata;
  logic [CNT_W-1:0]         cnt_rdata;
  logic [TAB_AW-1:0]        rom_addr;
  logic [GAIN_W-1:0]        rom_data;

  // select decode: negative -> none, above OUTPUTS -> last output
  logic [3:0]               sel_mag;
  logic [CUR_W-1:0]         sel_c;
  logic                     in_acc;
  logic                     out_free;
  logic                     i_full;
  logic [CNT_W-1:0]         cnt_cur;
  logic [CNT_W-1:0]         cnt_new;
  logic signed [PROD_W-1:0] rounded;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign i_full   = (i_r == TAB_AW'(SINE_ENTRIES));
  assign sel_mag  = in_select_out[SEL_W-2:0];
  assign sel_c    = in_select_out[SEL_W-1] ? '0 :
                    (32'(sel_mag) > OUTPUTS) ? CUR_W'(OUTPUTS) : CUR_W'(sel_mag);
  assign cnt_cur  = cnt_vld_r[k_r] ? cnt_rdata : '0;
  // floor((p + 2^14) / 2^15)
  assign rounded  = (prod_r + PROD_W'(16384)) >>> 15;

  // table address: T[i], then T[i+1] (held at the top entry)
  always_comb begin
    rom_addr = i_r;
    if (state_r == S_ROM1 && !i_full) rom_addr = i_r + TAB_AW'(1);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_MUL1: begin
        mul_a = MUL_AW'(c_r);
        mul_b = MUL_BW'(SINE_ENTRIES);
      end
      S_MUL2: begin
        mul_a = MUL_AW'(r_r);
        mul_b = MUL_BW'(t1_r - t0_r);
      end
      S_MUL3, S_OUT: begin
        // kept on through S_OUT so the product holds while the result register is busy
        mul_a = MUL_AW'(gain_r);
        mul_b = MUL_BW'(smp_r);   // sign-extends
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    cnt_vld_nxt   = cnt_vld_r;
    cur_nxt       = cur_r;
    k_nxt         = k_r;
    len_nxt       = len_r;
    smp_nxt       = smp_r;
    c_nxt         = c_r;
    faded_nxt     = faded_r;
    i_nxt         = i_r;
    r_nxt         = r_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    gain_nxt      = gain_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_ch_nxt    = out_ch_r;
    out_smp_nxt   = out_smp_r;
    out_fd_nxt    = out_fd_r;
    out_last_nxt  = out_last_r;
    cnt_we        = 1'b0;
    cnt_wdata     = '0;
    cnt_new       = cnt_cur;
    div_start     = 1'b0;
    div_dividend  = prod_r[DIVIDEND_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_action) begin
            // new output on, old one off; reselecting is a no-op
            if (sel_c != cur_r) begin
              for (int j = 0; j < OUTPUTS; j++) begin
                if (sel_c == CUR_W'(j + 1)) act_nxt[j] = 1'b1;
                if (cur_r == CUR_W'(j + 1)) act_nxt[j] = 1'b0;
              end
              cur_nxt = sel_c;
            end
          end else begin
            smp_nxt   = in_sample_in;
            len_nxt   = (fade_len_r == '0) ? CNT_W'(1) : fade_len_r;
            k_nxt     = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_RD: state_nxt = S_UPD;
      S_UPD: begin
        faded_nxt = 1'b0;
        if (act_r[k_r]) begin
          if (cnt_cur < len_r) cnt_new = cnt_cur + CNT_W'(1);
        end else if (cnt_cur != '0) begin
          cnt_new   = cnt_cur - CNT_W'(1);
          faded_nxt = (cnt_cur == CNT_W'(1));
        end
        cnt_we          = 1'b1;
        cnt_wdata       = cnt_new;
        cnt_vld_nxt[k_r] = 1'b1;
        c_nxt           = (cnt_new < len_r) ? cnt_new : len_r;
        state_nxt       = S_MUL1;
      end
      S_MUL1: state_nxt = S_DIV1;
      S_DIV1: begin
        div_start    = 1'b1;
        div_dividend = prod_r[DIVIDEND_W-1:0];
        state_nxt    = S_DIV1_W;
      end
      S_DIV1_W: begin
        if (div_done) begin
          i_nxt     = div_quot[TAB_AW-1:0];
          r_nxt     = div_rem;
          state_nxt = S_ROM0;
        end
      end
      S_ROM0: state_nxt = S_ROM1;
      S_ROM1: begin
        t0_nxt    = rom_data;
        state_nxt = S_ROM2;
      end
      S_ROM2: begin
        t1_nxt = rom_data;
        if (i_full) begin
          gain_nxt  = t0_r;
          state_nxt = S_MUL3;
        end else begin
          state_nxt = S_MUL2;
        end
      end
      S_MUL2: state_nxt = S_DIV2;
      S_DIV2: begin
        // rounded interpolation: (d*r + len/2) / len
        div_start    = 1'b1;
        div_dividend = prod_r[DIVIDEND_W-1:0] + DIVIDEND_W'(len_r >> 1);
        state_nxt    = S_DIV2_W;
      end
      S_DIV2_W: begin
        if (div_done) begin
          gain_nxt  = t0_r + div_quot[GAIN_W-1:0];
          state_nxt = S_MUL3;
        end
      end
      S_MUL3: state_nxt = S_OUT;
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = CH_W'(k_r);
          out_smp_nxt   = rounded[SMP_W-1:0];
          out_fd_nxt    = faded_r;
          out_last_nxt  = (k_r == IDX_W'(OUTPUTS - 1));
          if (k_r == IDX_W'(OUTPUTS - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      act_r       <= '0;
      cnt_vld_r   <= '0;
      cur_r       <= '0;
      fade_len_r  <= FADE_LENGTH_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      act_r       <= act_nxt;
      cnt_vld_r   <= cnt_vld_nxt;
      cur_r       <= cur_nxt;
      fade_len_r  <= fade_len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    len_r      <= len_nxt;
    smp_r      <= smp_nxt;
    c_r        <= c_nxt;
    faded_r    <= faded_nxt;
    i_r        <= i_nxt;
    r_r        <= r_nxt;
    t0_r       <= t0_nxt;
    t1_r       <= t1_nxt;
    gain_r     <= gain_nxt;
    prod_r     <= mul_a * mul_b;
    out_ch_r   <= out_ch_nxt;
    out_smp_r  <= out_smp_nxt;
    out_fd_r   <= out_fd_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_ch_r;
  assign out_sample_out = out_smp_r;
  assign out_faded_out  = out_fd_r;
  assign out_last       = out_last_r;

  // ---------------------------------------------------------------------
  // Submodules
  // ---------------------------------------------------------------------
  cfog_ram #(
    .WIDTH (CNT_W),
    .DEPTH (OUTPUTS)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (cnt_we),
    .wr_addr (k_r),
    .wr_data (cnt_wdata),
    .rd_addr (k_r),
    .rd_data (cnt_rdata)
  );

  cfog_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_sine_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  cfog_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (len_r),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // at most one output active, and exactly one while something is selected
  a_one_active: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(act_r) == ((cur_r != '0) ? 1 : 0))
    else $error("active flags disagree with selected output");

  // divider results only arrive while the sequencer waits for them
  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV1_W || state_r == S_DIV2_W))
    else $error("divider finished outside a wait state");

  // a sample request starts the sweep at output 0
  a_sweep_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_action) |=> (state_r == S_RD && k_r == '0))
    else $error("sample request did not start output sweep");

  // interpolated gain stays inside Q1.15
  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL3) |-> (gain_r[GAIN_W-1] == 1'b0))
    else $error("gain out of range");

  // the last flag closes a sweep: the sequencer is back to idle
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free && k_r == IDX_W'(OUTPUTS - 1)) |=>
      (state_r == S_IDLE && out_last_r))
    else $error("final result did not end the sweep");

endmodule

### rtl/cfog_ram.sv
// cfog_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cfog_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/cfog_sine_rom.sv
// cfog_sine_rom: quarter-sine table, entries+1 words of Q1.15, registered read.
// Contents built at elaboration from cfog_pkg::sine_q15.
module cfog_sine_rom
  import cfog_pkg::*;
#(
  parameter int SINE_ENTRIES = 1024,
  localparam int AW = $clog2(SINE_ENTRIES + 1)
) (
  input  logic              clk,
  input  logic [AW-1:0]     addr,
  output logic [GAIN_W-1:0] data
);

  logic [GAIN_W-1:0] tab [0:SINE_ENTRIES];
  logic [GAIN_W-1:0] data_r;

  for (genvar g = 0; g <= SINE_ENTRIES; g++) begin : g_tab
    localparam logic [63:0] X = (PI_HALF_Q30 * 64'(g)) / 64'(SINE_ENTRIES);
    assign tab[g] = sine_q15(X);
  end

  always_ff @(posedge clk) begin
    data_r <= tab[addr];
  end

  assign data = data_r;

endmodule

### rtl/cfog_divider.sv
// cfog_divider: restoring divider, one quotient bit per cycle.
// Shared by the table-index and interpolation divides. Uses cfog_pkg widths.
module cfog_divider
  import cfog_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [CNT_W-1:0]      divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [CNT_W-1:0]      remainder
);

  localparam int STEP_W = $clog2(DIVIDEND_W);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [DIVIDEND_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      dvs_r, dvs_nxt;
  logic [CNT_W:0]        rem_sh;
  logic                  ge;

  assign rem_sh = {rem_r, q_r[DIVIDEND_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[DIVIDEND_W-2:0], ge};
      rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[CNT_W-1:0];
      if (step_r == STEP_W'(DIVIDEND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r + STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r <= step_nxt;
    q_r    <= q_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;

endmodule
